// ===== src/crcbs_pkg.sv =====
// ----------------------------------------------------------------------------
// crcbs_pkg
// Shared constants, types and helpers for the bit-serial CRC generator and
// checker.
// ----------------------------------------------------------------------------
package crcbs_pkg;

  localparam int CRC_WIDTH   = 16;
  localparam int GEN_WIDTH   = 16;
  localparam int CNT_W       = $clog2(CRC_WIDTH + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [GEN_WIDTH-1:0] GEN_RESET = 16'h1021;

  // mode codes
  localparam logic MODE_GEN   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  // one classified bit on its way from the front end to the output side
  typedef struct packed {
    logic                 data_bit;
    logic                 last;
    logic                 error;
    logic                 tail;
    logic [CRC_WIDTH-1:0] crc;
  } entry_t;

  // low CRC_WIDTH generator coefficients from the 16-bit register
  function automatic logic [CRC_WIDTH-1:0] gen_coeffs(input logic [GEN_WIDTH-1:0] g);
    logic [63:0] wide;
    wide = {{(64 - GEN_WIDTH){1'b0}}, g};
    return wide[CRC_WIDTH-1:0];
  endfunction

endpackage

// ===== src/crcbs_front.sv =====
// ----------------------------------------------------------------------------
// crcbs_front
// Accepts input bits, runs the LFSR division and classifies each bit as a
// plain echo, a check-mode frame end or a generate-mode frame end with tail.
// ----------------------------------------------------------------------------
module crcbs_front
  import crcbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [GEN_WIDTH-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic                 data_bit,
  input  logic                 frame_end,
  output logic                 push_valid,
  input  logic                 push_ready,
  output entry_t               push_entry
);

  logic [GEN_WIDTH-1:0] generator_low;
  logic [CRC_WIDTH-1:0] remainder;
  logic [CRC_WIDTH-1:0] rem_shift;
  logic                 feedback;
  logic                 accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid & push_ready;

  always_comb begin
    feedback  = remainder[CRC_WIDTH-1] ^ data_bit;
    rem_shift = (remainder << 1) ^ (feedback ? gen_coeffs(generator_low) : '0);
  end

  always_comb begin
    push_entry.data_bit = data_bit;
    push_entry.last     = frame_end & (mode == MODE_CHECK);
    push_entry.error    = frame_end & (mode == MODE_CHECK) & (rem_shift != '0);
    push_entry.tail     = frame_end & (mode == MODE_GEN);
    push_entry.crc      = rem_shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      generator_low <= GEN_RESET;
    end else if (cfg_we) begin
      generator_low <= cfg_wdata;
    end
  end

  // remainder clears once the frame is done
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
    end else if (accept) begin
      remainder <= frame_end ? '0 : rem_shift;
    end
  end

endmodule

// ===== src/crcbs_queue.sv =====
// ----------------------------------------------------------------------------
// crcbs_queue
// Short FIFO between the front end and the output side, so the input keeps
// flowing while a check tail is being shifted out.
// ----------------------------------------------------------------------------
module crcbs_queue
  import crcbs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop,
  output entry_t pop_entry
);

  entry_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) && !do_push |=> (count == '0))
    else $error("queue count moved without a transfer");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != QCNT_W'(QUEUE_DEPTH)) && (count != '0) |-> (wr_ptr != rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

// ===== src/crcbs_back.sv =====
// ----------------------------------------------------------------------------
// crcbs_back
// Output side: echoes each queued bit and, after a generate-mode frame end,
// shifts out the remainder MSB first through the output register.
// ----------------------------------------------------------------------------
module crcbs_back
  import crcbs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pop_valid,
  output logic   pop,
  input  entry_t pop_entry,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   out_bit,
  output logic   is_check_bit,
  output logic   run_last,
  output logic   error
);

  logic                 out_load;
  logic                 tail_active;
  logic [CNT_W-1:0]     tail_count;
  logic [CRC_WIDTH-1:0] tail_shift;
  logic                 tail_done;

  assign out_load  = ~out_valid | out_ready;
  assign pop       = out_load & ~tail_active & pop_valid;
  assign tail_done = (tail_count == CNT_W'(CRC_WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      tail_active <= 1'b0;
      tail_count  <= '0;
    end else if (out_load) begin
      if (tail_active) begin
        out_valid  <= 1'b1;
        tail_count <= tail_done ? '0 : tail_count + 1'b1;
        if (tail_done) begin
          tail_active <= 1'b0;
        end
      end else if (pop_valid) begin
        out_valid   <= 1'b1;
        tail_active <= pop_entry.tail;
        tail_count  <= '0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (tail_active) begin
        out_bit      <= tail_shift[CRC_WIDTH-1];
        is_check_bit <= 1'b1;
        run_last     <= tail_done;
        error        <= 1'b0;
        tail_shift   <= tail_shift << 1;
      end else if (pop_valid) begin
        out_bit      <= pop_entry.data_bit;
        is_check_bit <= 1'b0;
        run_last     <= pop_entry.last;
        error        <= pop_entry.error;
        tail_shift   <= pop_entry.crc;
      end
    end
  end

  a_no_pop_in_tail: assert property (@(posedge clk) disable iff (rst)
    tail_active |-> !pop)
    else $error("queue popped while tail in progress");

  a_check_no_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_check_bit |-> !error)
    else $error("error flag on an appended check bit");

  a_tail_ends: assert property (@(posedge clk) disable iff (rst)
    tail_active && out_load && tail_done |=> out_valid && run_last && is_check_bit)
    else $error("tail did not finish with a marked check bit");

endmodule

// ===== src/crc16_bit_serial_gen_check.sv =====
// ----------------------------------------------------------------------------
// crc16_bit_serial_gen_check
// Bit-serial CRC generator and checker, MSB first, zero initial remainder.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one bit per transfer with mode and
// frame_end; output channel (out_valid/out_ready) gives one result bit per
// transfer. Every input bit is echoed. In generate mode a frame end is
// followed by the 16 remainder bits, the last one flagged with run_last; in
// check mode the echo of the frame end carries run_last and error.
// An input transfer is written into the queue and then loaded into the
// output register when that register is free.
// Throughput is one bit per clock in both directions while out_ready is high;
// a generate frame end adds 16 output bits, during which a
// four-entry queue absorbs input before in_ready drops.
// cfg_we writes the generator coefficients below the implicit top term
// (reset 0x1021); write only while the block is idle.
// Synchronous reset clears the remainder, the queue and the output valid.
// When out_ready is low the output register holds, the queue fills and
// in_ready falls once it is full; nothing is lost.
// ----------------------------------------------------------------------------
module crc16_bit_serial_gen_check
  import crcbs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [GEN_WIDTH-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 mode,
  input  logic                 data_bit,
  input  logic                 frame_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_bit,
  output logic                 is_check_bit,
  output logic                 run_last,
  output logic                 error
);

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop;
  entry_t pop_entry;

  crcbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .data_bit   (data_bit),
    .frame_end  (frame_end),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  crcbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  crcbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop          (pop),
    .pop_entry    (pop_entry),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_bit      (out_bit),
    .is_check_bit (is_check_bit),
    .run_last     (run_last),
    .error        (error)
  );

endmodule

// ===== tb/crc16_bit_serial_gen_check_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_bit_serial_gen_check_tb
// Drives single-bit frames, mixed-mode frames, generated frames followed by
// their codewords (clean or with one flipped bit) and random noise frames
// through the CRC block under several generator settings, with sender gaps,
// receiver stalls and one long output hold. Every result transfer is checked
// field by field against an in-order LFSR prediction.
// ----------------------------------------------------------------------------
module crc16_bit_serial_gen_check_tb;
  import crcbs_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 8;

  typedef logic bit_queue_t[$];

  typedef struct packed {
    logic out_bit;
    logic is_check_bit;
    logic run_last;
    logic error;
  } crc_result_t;

  typedef enum int {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_style_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [GEN_WIDTH-1:0] cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 mode;
  logic                 data_bit;
  logic                 frame_end;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_bit;
  logic                 is_check_bit;
  logic                 run_last;
  logic                 error;

  // predictor state
  logic [GEN_WIDTH-1:0] gen_poly = GEN_RESET;
  logic [CRC_WIDTH-1:0] crc_rem  = '0;
  crc_result_t          expected_results[$];

  int        fail_count    = 0;
  int        result_count  = 0;
  int        sent_count    = 0;
  int        cycle_count   = 0;
  int        burst_left    = 0;
  int        gap_limit     = 0;
  rx_style_t rx_style      = RX_ALWAYS;
  int        hold_requests = 0;
  int        hold_length   = 0;

  // receiver-side bookkeeping, written only by the stall process
  int hold_seen  = 0;
  int hold_left  = 0;
  int stall_tick = 0;

  crc16_bit_serial_gen_check dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .data_bit     (data_bit),
    .frame_end    (frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_bit      (out_bit),
    .is_check_bit (is_check_bit),
    .run_last     (run_last),
    .error        (error)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [CRC_WIDTH-1:0] lfsr_shift(input logic [CRC_WIDTH-1:0] r,
                                                      input logic b,
                                                      input logic [GEN_WIDTH-1:0] g);
    logic fb;
    fb = r[CRC_WIDTH-1] ^ b;
    r  = r << 1;
    if (fb) r = r ^ g[CRC_WIDTH-1:0];
    return r;
  endfunction

  // remainder a generate frame of these bits ends with
  function automatic logic [CRC_WIDTH-1:0] crc_over(input bit_queue_t bits);
    logic [CRC_WIDTH-1:0] r;
    r = '0;
    foreach (bits[i]) r = lfsr_shift(r, bits[i], gen_poly);
    return r;
  endfunction

  task automatic predict_bit(input logic m, input logic b, input logic e);
    crc_rem = lfsr_shift(crc_rem, b, gen_poly);
    if (!e) begin
      expected_results.push_back('{b, 1'b0, 1'b0, 1'b0});
    end else if (m == MODE_CHECK) begin
      expected_results.push_back('{b, 1'b0, 1'b1, crc_rem != '0});
      crc_rem = '0;
    end else begin
      expected_results.push_back('{b, 1'b0, 1'b0, 1'b0});
      for (int i = CRC_WIDTH - 1; i >= 0; i--)
        expected_results.push_back('{crc_rem[i], 1'b1, i == 0, 1'b0});
      crc_rem = '0;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int idx, input logic got,
                             input logic want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %b want %b", idx, name, got, want));
  endtask

  // receiver: a long hold when asked, otherwise the current stall style
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = hold_length;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_style)
        RX_ALWAYS:  out_ready <= 1'b1;
        RX_PATTERN: out_ready <= (stall_tick % 7) < 4;
        default:    out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
    stall_tick++;
  end

  always @(posedge clk) begin : result_check
    crc_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d out_bit=%b run_last=%b",
                                  result_count, out_bit, run_last));
      end else begin
        want = expected_results.pop_front();
        check_field("out_bit", result_count, out_bit, want.out_bit);
        check_field("is_check_bit", result_count, is_check_bit, want.is_check_bit);
        check_field("run_last", result_count, run_last, want.run_last);
        check_field("error", result_count, error, want.error);
      end
      result_count++;
    end
  end

  task automatic send_bit(input logic m, input logic b, input logic e);
    int gap;
    if (gap_limit > 0 && burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = $urandom_range(0, gap_limit);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_valid  <= 1'b1;
    mode      <= m;
    data_bit  <= b;
    frame_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_bit(m, b, e);
    sent_count++;
  endtask

  task automatic send_frame(input logic m, input bit_queue_t bits);
    foreach (bits[i]) send_bit(m, bits[i], i == bits.size() - 1);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_generator(input logic [GEN_WIDTH-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    gen_poly = value;
  endtask

  task automatic test_single_bit_frames();
    send_bit(MODE_GEN, 1'b1, 1'b1);
    send_bit(MODE_CHECK, 1'b0, 1'b1);
    send_bit(MODE_CHECK, 1'b1, 1'b1);
    send_bit(MODE_GEN, 1'b0, 1'b1);
    wait_idle();
  endtask

  // check-mode bit followed by a generate-mode frame end: tail is appended
  task automatic test_mixed_mode_frame();
    send_bit(MODE_CHECK, 1'b1, 1'b0);
    send_bit(MODE_GEN, 1'b0, 1'b1);
    wait_idle();
  endtask

  task automatic test_generate_then_check();
    bit_queue_t           msg;
    bit_queue_t           word;
    logic [CRC_WIDTH-1:0] chk;
    msg = '{1'b1, 1'b0};
    send_frame(MODE_GEN, msg);
    chk  = crc_over(msg);
    word = msg;
    for (int i = CRC_WIDTH - 1; i >= 0; i--) word.push_back(chk[i]);
    send_frame(MODE_CHECK, word);
    wait_idle();
  endtask

  task automatic random_frame();
    int                   kind;
    int                   len;
    int                   flip;
    bit_queue_t           msg;
    bit_queue_t           word;
    logic [CRC_WIDTH-1:0] chk;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) msg.push_back(1'($urandom_range(0, 1)));
      send_frame(MODE_GEN, msg);
      if (kind < 4) begin
        chk  = crc_over(msg);
        word = msg;
        for (int i = CRC_WIDTH - 1; i >= 0; i--) word.push_back(chk[i]);
        // corrupt roughly a third of the codewords
        if ($urandom_range(0, 2) == 0) begin
          flip = $urandom_range(0, word.size() - 1);
          word[flip] = ~word[flip];
        end
        send_frame(MODE_CHECK, word);
      end
    end else if (kind < 8) begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) msg.push_back(1'($urandom_range(0, 1)));
      send_frame(MODE_CHECK, msg);
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        send_bit(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), i == len - 1);
    end
  endtask

  task automatic test_generator_sweep();
    logic [GEN_WIDTH-1:0] sweep_gens[5];
    int                   start;
    sweep_gens[0] = 16'hFFFF;
    sweep_gens[1] = 16'h0000;
    sweep_gens[2] = 16'h8005;
    sweep_gens[3] = 16'($urandom);
    sweep_gens[4] = GEN_RESET;
    for (int p = 0; p < 5; p++) begin
      write_generator(sweep_gens[p]);
      rx_style  = rx_style_t'(p % 3);
      gap_limit = (p == 0) ? 0 : 2 * p;
      start = sent_count;
      while (sent_count - start < PHASE_ITEMS) random_frame();
      wait_idle();
    end
  endtask

  // receiver holds off long enough for the block to fill and drop in_ready
  task automatic test_output_hold();
    bit_queue_t msg;
    rx_style  = RX_ALWAYS;
    gap_limit = 0;
    hold_length = 300;
    hold_requests++;
    for (int i = 0; i < 5; i++) msg.push_back(1'($urandom_range(0, 1)));
    send_frame(MODE_GEN, msg);
    msg.delete();
    for (int i = 0; i < 10; i++) msg.push_back(1'($urandom_range(0, 1)));
    send_frame(MODE_CHECK, msg);
    wait_idle();
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    mode      <= MODE_GEN;
    data_bit  <= 1'b0;
    frame_end <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_single_bit_frames();
    test_mixed_mode_frame();
    test_generate_then_check();
    test_output_hold();
    test_generator_sweep();

    while (expected_results.size() != 0)
      report_mismatch($sformatf("missing result, out_bit=%b",
                                expected_results.pop_front().out_bit));
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
